>>> src/dvu_pkg.sv
// dvu_pkg: shared types and constants of the distance-vector update block
// holds request/response structs, function codes and register indexes
// no dependencies
package dvu_pkg;

   // default sizing
   localparam int NODES_DEF     = 8;
   localparam int COST_BITS_DEF = 16;

   // field widths fixed by the interface
   localparam int FUNC_W  = 2;
   localparam int NODE_W  = 3;
   localparam int PORT_W  = 16;
   localparam int ACOST_W = 16;

   // function codes (the unused code behaves as a read)
   localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADVERT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

   // register file
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_INDEX = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_BASE = 1'b1;

   // register reset values
   localparam logic [NODE_W-1:0] OWN_INDEX_RST = 3'd0;
   localparam logic [PORT_W-1:0] PORT_BASE_RST = 16'd10000;

   // one request
   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [NODE_W-1:0]  sender;
      logic [NODE_W-1:0]  dest;
      logic [ACOST_W-1:0] adv_cost;
      logic [PORT_W-1:0]  adv_dest_port;
      logic               last_entry;
   } req_type;

   // one response
   typedef struct packed {
      logic [ACOST_W-1:0] rd_cost;
      logic [PORT_W-1:0]  rd_next_port;
      logic [PORT_W-1:0]  rd_dest_port;
      logic               entry_changed;
      logic               vector_changed;
   } rsp_type;

endpackage

>>> src/dvu_table.sv
// dvu_table: routing table memory with two registered read ports and one write port
// entries not yet written read as the reset entry; same-edge writes are forwarded
// depends on dvu_pkg
module dvu_table #(
   parameter int NODES     = dvu_pkg::NODES_DEF,
   parameter int COST_BITS = dvu_pkg::COST_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      rd_en,
   input  logic [$clog2(NODES)-1:0]                  rd_snd_idx,
   input  logic [$clog2(NODES)-1:0]                  rd_dst_idx,
   input  logic                                      wr_en,
   input  logic [$clog2(NODES)-1:0]                  wr_idx,
   input  logic [COST_BITS+2*dvu_pkg::PORT_W-1:0]    wr_data,
   output logic [COST_BITS+2*dvu_pkg::PORT_W-1:0]    snd_entry,
   output logic [COST_BITS+2*dvu_pkg::PORT_W-1:0]    dst_entry
);

   localparam int IDX_W = $clog2(NODES);
   localparam int EW    = COST_BITS + 2 * dvu_pkg::PORT_W;
   localparam logic [EW-1:0] ENTRY_RST = {{COST_BITS{1'b1}}, {(2 * dvu_pkg::PORT_W){1'b0}}};

   logic [EW-1:0]    mem [NODES];
   logic [NODES-1:0] valid_ff;
   logic [EW-1:0]    rd_snd_ff;
   logic [EW-1:0]    rd_dst_ff;
   logic [IDX_W-1:0] snd_idx_ff;
   logic [IDX_W-1:0] dst_idx_ff;
   logic             fwd_snd_ff;
   logic             fwd_dst_ff;
   logic [EW-1:0]    fwd_data_ff;

   // memory write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   // memory read ports, data registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_snd_ff <= mem[rd_snd_idx];
         rd_dst_ff <= mem[rd_dst_idx];
      end
   end

   // read-side bookkeeping and forwarding of a write on the read edge
   always_ff @(posedge clock) begin
      if (rd_en) begin
         snd_idx_ff  <= rd_snd_idx;
         dst_idx_ff  <= rd_dst_idx;
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_snd_ff <= 1'b0;
         fwd_dst_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_snd_ff <= wr_en && (wr_idx == rd_snd_idx);
         fwd_dst_ff <= wr_en && (wr_idx == rd_dst_idx);
      end
   end

   // per-entry written flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   // resolve forwarded, stored or reset entry
   always_comb begin
      priority if (fwd_snd_ff) begin
         snd_entry = fwd_data_ff;
      end else if (valid_ff[snd_idx_ff]) begin
         snd_entry = rd_snd_ff;
      end else begin
         snd_entry = ENTRY_RST;
      end
   end

   always_comb begin
      priority if (fwd_dst_ff) begin
         dst_entry = fwd_data_ff;
      end else if (valid_ff[dst_idx_ff]) begin
         dst_entry = rd_dst_ff;
      end else begin
         dst_entry = ENTRY_RST;
      end
   end

endmodule

>>> src/distance_vector_update_core.sv
// Distance-vector routing table of one node. Each request carries one table entry and gives
// exactly one response: a load writes the entry, an advert relaxes it against the advertised
// cost plus the stored cost to the sender (saturating at the all-ones infinite cost), and a read
// returns it. The block takes one request per cycle when the response side keeps up; a request
// passes first through the registered table read of the sender and destination entries, then
// through the add, compare and write-back into the response register. A write on the
// same edge as the next read is forwarded, so back-to-back requests on the same entries see the
// latest values. Table contents start at their reset values through per-entry written flags;
// no clearing pass is needed after reset.
// depends on dvu_pkg, dvu_table
module distance_vector_update_core #(
   parameter int NODES     = dvu_pkg::NODES_DEF,
   parameter int COST_BITS = dvu_pkg::COST_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  dvu_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output dvu_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [dvu_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dvu_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W = $clog2(NODES);
   localparam int PW    = dvu_pkg::PORT_W;
   localparam int EW    = COST_BITS + 2 * PW;
   localparam logic [COST_BITS-1:0] COST_INF = {COST_BITS{1'b1}};

   // configuration registers
   logic [dvu_pkg::NODE_W-1:0] own_index_ff;
   logic [PW-1:0]              port_base_ff;

   // pipeline state
   logic             s1_valid_ff, s1_valid_in;
   dvu_pkg::req_type s1_req_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   dvu_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             any_change_ff, any_change_in;

   // handshake
   logic req_fire, out_free, s1_fire;

   // table interface
   logic             tbl_wr_en;
   logic [IDX_W-1:0] tbl_wr_idx;
   logic [EW-1:0]    tbl_wr_data;
   logic [EW-1:0]    snd_entry, dst_entry, new_entry;

   // update datapath
   logic                 dest_ok, sender_ok, is_load, is_adv;
   logic [COST_BITS-1:0] adv_cost, link_cost, dst_cost, sum_sat;
   logic [COST_BITS:0]   sum_full;
   logic [PW-1:0]        hop_port;
   logic                 relax_ok, changed, write_entry, vec;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         own_index_ff <= dvu_pkg::OWN_INDEX_RST;
         port_base_ff <= dvu_pkg::PORT_BASE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            dvu_pkg::CSR_OWN_INDEX: own_index_ff <= csr_wdata[dvu_pkg::NODE_W-1:0];
            dvu_pkg::CSR_PORT_BASE: port_base_ff <= csr_wdata[PW-1:0];
            default: ;
         endcase
      end
   end

   // flow control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_fire  = req_valid && !req_stall;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         any_change_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         any_change_ff <= any_change_in;
      end
   end

   // request held while its table read is in flight
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff <= req_data;
      end
   end

   // table memory
   dvu_table #(
      .NODES     (NODES),
      .COST_BITS (COST_BITS)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (req_fire),
      .rd_snd_idx (IDX_W'(req_data.sender)),
      .rd_dst_idx (IDX_W'(req_data.dest)),
      .wr_en      (tbl_wr_en),
      .wr_idx     (tbl_wr_idx),
      .wr_data    (tbl_wr_data),
      .snd_entry  (snd_entry),
      .dst_entry  (dst_entry)
   );

   // decode of the held request
   assign dest_ok   = 32'(s1_req_ff.dest) < 32'(NODES);
   assign sender_ok = 32'(s1_req_ff.sender) < 32'(NODES);
   assign is_load   = s1_req_ff.func == dvu_pkg::FUNC_LOAD;
   assign is_adv    = s1_req_ff.func == dvu_pkg::FUNC_ADVERT;

   // relaxation: saturating add and compare
   assign adv_cost  = COST_BITS'(s1_req_ff.adv_cost);
   assign link_cost = snd_entry[EW-1 -: COST_BITS];
   assign dst_cost  = dst_entry[EW-1 -: COST_BITS];
   assign sum_full  = {1'b0, adv_cost} + {1'b0, link_cost};
   assign sum_sat   = sum_full[COST_BITS] ? COST_INF : sum_full[COST_BITS-1:0];
   assign hop_port  = port_base_ff + PW'(s1_req_ff.sender);

   assign relax_ok = is_adv && dest_ok && (s1_req_ff.dest != own_index_ff)
                     && (adv_cost != COST_INF) && sender_ok && (link_cost != COST_INF);
   assign changed     = relax_ok && (dst_cost > sum_sat);
   assign write_entry = dest_ok && (is_load || changed);

   // write-back
   assign tbl_wr_en   = s1_fire && write_entry;
   assign tbl_wr_idx  = IDX_W'(s1_req_ff.dest);
   assign tbl_wr_data = is_load ? {adv_cost, port_base_ff, s1_req_ff.adv_dest_port}
                                : {sum_sat, hop_port, s1_req_ff.adv_dest_port};
   assign new_entry   = write_entry ? tbl_wr_data : dst_entry;

   // vector change tracking
   assign vec = is_adv && s1_req_ff.last_entry && (any_change_ff || changed);

   always_comb begin
      any_change_in = any_change_ff;
      if (s1_fire && is_adv) begin
         priority if (s1_req_ff.last_entry) begin
            any_change_in = 1'b0;
         end else if (changed) begin
            any_change_in = 1'b1;
         end
      end
   end

   // response register
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (s1_fire) begin
         if (dest_ok) begin
            rsp_data_in.rd_cost      = dvu_pkg::ACOST_W'(new_entry[EW-1 -: COST_BITS]);
            rsp_data_in.rd_next_port = new_entry[2*PW-1:PW];
            rsp_data_in.rd_dest_port = new_entry[PW-1:0];
         end else begin
            rsp_data_in.rd_cost      = '0;
            rsp_data_in.rd_next_port = '0;
            rsp_data_in.rd_dest_port = '0;
         end
         rsp_data_in.entry_changed  = changed;
         rsp_data_in.vector_changed = vec;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> src/dvu_checker.sv
// dvu_checker: port-level checks of the distance-vector update block
// bound to distance_vector_update_core; depends on dvu_pkg
module dvu_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input dvu_pkg::rsp_type rsp_data
);

   logic [1:0] pending_ff, pending_in;
   logic       in_fire, out_fire;

   assign in_fire  = req_valid && !req_stall;
   assign out_fire = rsp_valid && !rsp_stall;

   // count of requests accepted but not yet answered
   always_comb begin
      pending_in = pending_ff;
      unique case ({in_fire, out_fire})
         2'b10:   pending_in = pending_ff + 2'd1;
         2'b01:   pending_in = pending_ff - 2'd1;
         default: pending_in = pending_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // no response right after reset
   a_rst_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // every response answers an accepted request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without request");

   // at most two requests in flight
   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("too many requests in flight");

endmodule

bind distance_vector_update_core dvu_checker u_dvu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> sim/dvu_route_checker.sv
`timescale 1ns / 1ps
// dvu_route_checker: watches the request, response and register ports of the
// distance-vector update core, predicts each response and compares it field by field
// depends on dvu_pkg
module dvu_route_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  dvu_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  dvu_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [dvu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dvu_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             pending_count
);

   localparam logic [dvu_pkg::ACOST_W-1:0] COST_INF = '1;
   localparam int PRINT_CAP = 60;

   // shadow routing table and registers
   logic [dvu_pkg::ACOST_W-1:0] cost_tab  [dvu_pkg::NODES_DEF];
   logic [dvu_pkg::PORT_W-1:0]  hop_tab   [dvu_pkg::NODES_DEF];
   logic [dvu_pkg::PORT_W-1:0]  dport_tab [dvu_pkg::NODES_DEF];
   logic                        vec_dirty;
   logic [dvu_pkg::NODE_W-1:0]  own_q;
   logic [dvu_pkg::PORT_W-1:0]  base_q;
   int                          n;

   // responses still owed by the core, oldest first
   dvu_pkg::rsp_type expected_routes[$];
   dvu_pkg::rsp_type want_route;

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (fail_count < PRINT_CAP)
         $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
      fail_count++;
   endtask

   // apply one request to the shadow table and return the entry it reads back
   function automatic dvu_pkg::rsp_type relax_entry(input dvu_pkg::req_type r);
      dvu_pkg::rsp_type res;
      logic [16:0]      sum;
      logic             changed;
      res     = '0;
      changed = 1'b0;
      unique case (r.func)
         dvu_pkg::FUNC_LOAD: begin
            cost_tab[r.dest]  = r.adv_cost;
            hop_tab[r.dest]   = base_q;
            dport_tab[r.dest] = r.adv_dest_port;
         end
         dvu_pkg::FUNC_ADVERT: begin
            // own entry, infinite advert and unreachable sender leave the table alone
            if (r.dest != own_q && r.adv_cost != COST_INF && cost_tab[r.sender] != COST_INF) begin
               sum = {1'b0, r.adv_cost} + {1'b0, cost_tab[r.sender]};
               if (sum > {1'b0, COST_INF})
                  sum = {1'b0, COST_INF};
               if ({1'b0, cost_tab[r.dest]} > sum) begin
                  cost_tab[r.dest]  = sum[dvu_pkg::ACOST_W-1:0];
                  hop_tab[r.dest]   = base_q + dvu_pkg::PORT_W'(r.sender);
                  dport_tab[r.dest] = r.adv_dest_port;
                  changed           = 1'b1;
               end
            end
            // vector flag is reported and cleared on the last entry
            if (r.last_entry) begin
               res.vector_changed = vec_dirty | changed;
               vec_dirty          = 1'b0;
            end else if (changed) begin
               vec_dirty = 1'b1;
            end
         end
         default: ;
      endcase
      res.rd_cost       = cost_tab[r.dest];
      res.rd_next_port  = hop_tab[r.dest];
      res.rd_dest_port  = dport_tab[r.dest];
      res.entry_changed = changed;
      return res;
   endfunction

   // sample all ports at the clock edge, before the core updates them
   always @(posedge clock) begin
      if (reset) begin
         for (n = 0; n < dvu_pkg::NODES_DEF; n++) begin
            cost_tab[n]  = COST_INF;
            hop_tab[n]   = '0;
            dport_tab[n] = '0;
         end
         vec_dirty  = 1'b0;
         own_q      = dvu_pkg::OWN_INDEX_RST;
         base_q     = dvu_pkg::PORT_BASE_RST;
         fail_count = 0;
         expected_routes.delete();
      end else begin
         // register writes
         if (csr_we) begin
            if (csr_index == dvu_pkg::CSR_OWN_INDEX)
               own_q = csr_wdata[dvu_pkg::NODE_W-1:0];
            else if (csr_index == dvu_pkg::CSR_PORT_BASE)
               base_q = csr_wdata[dvu_pkg::PORT_W-1:0];
         end

         // accepted request
         if (req_valid && !req_stall)
            expected_routes.push_back(relax_entry(req_data));

         // accepted response
         if (rsp_valid && !rsp_stall) begin
            if (expected_routes.size() == 0) begin
               report_mismatch("response with no request pending", rsp_data.rd_cost, '0);
            end else begin
               want_route = expected_routes.pop_front();
               if (rsp_data.rd_cost !== want_route.rd_cost)
                  report_mismatch("rd_cost", rsp_data.rd_cost, want_route.rd_cost);
               if (rsp_data.rd_next_port !== want_route.rd_next_port)
                  report_mismatch("rd_next_port", rsp_data.rd_next_port, want_route.rd_next_port);
               if (rsp_data.rd_dest_port !== want_route.rd_dest_port)
                  report_mismatch("rd_dest_port", rsp_data.rd_dest_port, want_route.rd_dest_port);
               if (rsp_data.entry_changed !== want_route.entry_changed)
                  report_mismatch("entry_changed", 16'(rsp_data.entry_changed),
                                  16'(want_route.entry_changed));
               if (rsp_data.vector_changed !== want_route.vector_changed)
                  report_mismatch("vector_changed", 16'(rsp_data.vector_changed),
                                  16'(want_route.vector_changed));
            end
         end
      end
      pending_count = expected_routes.size();
   end

endmodule

>>> sim/distance_vector_update_core_tb.sv
`timescale 1ns / 1ps
// distance_vector_update_core_tb: drives requests, register writes and response stalls
// into the distance-vector update core; the route checker predicts and compares
// depends on dvu_pkg, distance_vector_update_core, dvu_route_checker
module distance_vector_update_core_tb;

   localparam logic [dvu_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;
   localparam int IDLE_PCT    = 30;
   localparam int HOLD_CYCLES = 150;
   localparam int STALL_LIMIT = 3000;
   localparam int PHASE_ITEMS = 380;
   localparam int PHASES      = 5;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   dvu_pkg::req_type               req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   dvu_pkg::rsp_type               rsp_data;
   logic                           csr_we    = 1'b0;
   logic [dvu_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [dvu_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   int                             fail_count;
   int                             pending_count;
   bit                             steady_flow = 1'b0;
   int                             stuck_cycles;

   distance_vector_update_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dvu_route_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // 100 MHz clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic dvu_pkg::req_type make_request(
         input logic [dvu_pkg::FUNC_W-1:0]  func,
         input logic [dvu_pkg::NODE_W-1:0]  sender,
         input logic [dvu_pkg::NODE_W-1:0]  dest,
         input logic [dvu_pkg::ACOST_W-1:0] cost,
         input logic [dvu_pkg::PORT_W-1:0]  dport,
         input logic                        last);
      dvu_pkg::req_type r;
      r.func          = func;
      r.sender        = sender;
      r.dest          = dest;
      r.adv_cost      = cost;
      r.adv_dest_port = dport;
      r.last_entry    = last;
      return r;
   endfunction

   // mostly small costs so that relaxations happen, with the extremes mixed in
   function automatic logic [dvu_pkg::ACOST_W-1:0] pick_cost();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return dvu_pkg::ACOST_W'($urandom_range(0, 40));
      else if (roll < 70)
         return '1;
      else if (roll < 75)
         return 16'hFFFE;
      else if (roll < 80)
         return '0;
      return dvu_pkg::ACOST_W'($urandom);
   endfunction

   // offer one request, with an occasional gap first, and hold it until accepted
   task automatic send_request(input dvu_pkg::req_type r);
      if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop offering and wait until every response is back
   task automatic drain_requests();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic set_routing_regs(input logic [dvu_pkg::NODE_W-1:0] own,
                                   input logic [dvu_pkg::PORT_W-1:0] base);
      csr_we    <= 1'b1;
      csr_index <= dvu_pkg::CSR_OWN_INDEX;
      csr_wdata <= {(dvu_pkg::CSR_DATA_W - dvu_pkg::NODE_W)'($urandom), own};
      @(posedge clock);
      csr_index <= dvu_pkg::CSR_PORT_BASE;
      csr_wdata <= base;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // random traffic: mostly advert vectors from one sender, plus loads, reads and broken vectors
   task automatic run_traffic(input int unsigned n_items);
      int unsigned                sent;
      int unsigned                len;
      int unsigned                k;
      int unsigned                roll;
      logic [dvu_pkg::NODE_W-1:0] from;
      logic                       last;
      sent = 0;
      while (sent < n_items) begin
         roll = $urandom_range(0, 99);
         if (roll < 15) begin
            send_request(make_request(dvu_pkg::FUNC_LOAD, dvu_pkg::NODE_W'($urandom),
                                      dvu_pkg::NODE_W'($urandom), pick_cost(),
                                      dvu_pkg::PORT_W'($urandom), 1'($urandom)));
            sent++;
         end else if (roll < 25) begin
            send_request(make_request(($urandom_range(0, 3) == 0) ? FUNC_SPARE
                                                                  : dvu_pkg::FUNC_READ,
                                      dvu_pkg::NODE_W'($urandom), dvu_pkg::NODE_W'($urandom),
                                      dvu_pkg::ACOST_W'($urandom),
                                      dvu_pkg::PORT_W'($urandom), 1'($urandom)));
            sent++;
         end else begin
            from = dvu_pkg::NODE_W'($urandom);
            len  = $urandom_range(1, 8);
            for (k = 0; k < len; k++) begin
               // now and then the closing entry is missing
               last = (k == len - 1) && ($urandom_range(0, 9) != 0);
               send_request(make_request(dvu_pkg::FUNC_ADVERT, from,
                                         dvu_pkg::NODE_W'($urandom), pick_cost(),
                                         dvu_pkg::PORT_W'($urandom), last));
            end
            sent += len;
         end
      end
   endtask

   // response side: random stalls, and long hold-offs that back the core up
   initial begin : response_side
      int unsigned taken;
      int unsigned next_hold;
      taken     = 0;
      next_hold = 250;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall)
            taken++;
         if (taken >= next_hold) begin
            next_hold += 850;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= !steady_flow && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   initial begin : watchdog
      stuck_cycles = 0;
      while (stuck_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles = 0;
         else
            stuck_cycles++;
      end
      $display("distance_vector_update_core_tb: FAIL");
      $finish;
   end

   initial begin : stimulus
      logic [dvu_pkg::NODE_W-1:0] own_set  [PHASES];
      logic [dvu_pkg::PORT_W-1:0] base_set [PHASES];
      int                         ph;
      own_set  = '{3'd7, 3'd0, 3'd3, 3'd0, 3'd7};
      base_set = '{16'hFFFF, 16'h0000, 16'd10000, 16'h0000, 16'hFFF9};
      own_set[3]  = dvu_pkg::NODE_W'($urandom);
      base_set[3] = dvu_pkg::PORT_W'($urandom);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part with reset register values: own node 0, base port 10000
      send_request(make_request(dvu_pkg::FUNC_READ,   3'd0, 3'd0, 16'h0000, 16'h0000, 1'b0));
      // unreachable sender blocks the advert
      send_request(make_request(dvu_pkg::FUNC_ADVERT, 3'd2, 3'd4, 16'h0003, 16'h1111, 1'b0));
      send_request(make_request(dvu_pkg::FUNC_LOAD,   3'd0, 3'd3, 16'h0005, 16'hAAAA, 1'b0));
      send_request(make_request(dvu_pkg::FUNC_LOAD,   3'd0, 3'd0, 16'h0000, 16'h1234, 1'b0));
      // improve, equal cost, improve again
      send_request(make_request(dvu_pkg::FUNC_ADVERT, 3'd3, 3'd5, 16'd10,   16'h2222, 1'b0));
      send_request(make_request(dvu_pkg::FUNC_ADVERT, 3'd3, 3'd5, 16'd10,   16'h3333, 1'b0));
      send_request(make_request(dvu_pkg::FUNC_ADVERT, 3'd3, 3'd5, 16'd9,    16'h4444, 1'b0));
      // own entry, infinite advert, saturating sum
      send_request(make_request(dvu_pkg::FUNC_ADVERT, 3'd3, 3'd0, 16'h0000, 16'h5555, 1'b0));
      send_request(make_request(dvu_pkg::FUNC_ADVERT, 3'd3, 3'd6, 16'hFFFF, 16'h6666, 1'b0));
      send_request(make_request(dvu_pkg::FUNC_ADVERT, 3'd3, 3'd6, 16'hFFFE, 16'h7777, 1'b0));
      // vector close with and without a change
      send_request(make_request(dvu_pkg::FUNC_ADVERT, 3'd3, 3'd7, 16'h0000, 16'h8888, 1'b1));
      send_request(make_request(dvu_pkg::FUNC_ADVERT, 3'd3, 3'd7, 16'd20,   16'h9999, 1'b1));
      // infinite link loaded, then used
      send_request(make_request(dvu_pkg::FUNC_LOAD,   3'd5, 3'd2, 16'hFFFF, 16'h5555, 1'b1));
      send_request(make_request(dvu_pkg::FUNC_ADVERT, 3'd2, 3'd1, 16'h0001, 16'hBBBB, 1'b1));
      // spare function code and a plain read, ignored fields all ones
      send_request(make_request(FUNC_SPARE,           3'd7, 3'd5, 16'hFFFF, 16'hFFFF, 1'b1));
      send_request(make_request(dvu_pkg::FUNC_READ,   3'd7, 3'd7, 16'hFFFF, 16'hFFFF, 1'b1));
      // zero-cost link and zero-cost advert
      send_request(make_request(dvu_pkg::FUNC_LOAD,   3'd0, 3'd1, 16'h0000, 16'hFFFF, 1'b0));
      send_request(make_request(dvu_pkg::FUNC_ADVERT, 3'd1, 3'd4, 16'h0000, 16'hCCCC, 1'b0));
      send_request(make_request(dvu_pkg::FUNC_ADVERT, 3'd3, 3'd4, 16'h0000, 16'hDDDD, 1'b1));
      // largest finite link, sums that reach or overflow the infinite cost
      send_request(make_request(dvu_pkg::FUNC_LOAD,   3'd7, 3'd7, 16'hFFFE, 16'hFFFF, 1'b1));
      send_request(make_request(dvu_pkg::FUNC_ADVERT, 3'd7, 3'd6, 16'h0001, 16'hEEEE, 1'b0));
      send_request(make_request(dvu_pkg::FUNC_ADVERT, 3'd7, 3'd6, 16'hFFFE, 16'hEEEE, 1'b1));
      // sender advertising its own entry
      send_request(make_request(dvu_pkg::FUNC_ADVERT, 3'd1, 3'd1, 16'h0000, 16'h0101, 1'b1));

      // random phases, each with its own register setting
      for (ph = 0; ph < PHASES; ph++) begin
         drain_requests();
         steady_flow = (ph == 2);
         set_routing_regs(own_set[ph], base_set[ph]);
         run_traffic(PHASE_ITEMS);
      end

      drain_requests();
      repeat (6) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("distance_vector_update_core_tb: PASS");
      else
         $display("distance_vector_update_core_tb: FAIL");
      $finish;
   end

endmodule
